FILE: rtl/lab_pkg.sv
// ----------------------------------------------------------------------------
// lab_pkg: shared types for the look-at basis block
// Transaction payloads, the queued job record and the engine state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lab_pkg;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] upvec_x;
    logic signed [31:0] upvec_y;
    logic signed [31:0] upvec_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] side_x;
    logic signed [31:0] side_y;
    logic signed [31:0] side_z;
    logic signed [31:0] true_up_x;
    logic signed [31:0] true_up_y;
    logic signed [31:0] true_up_z;
    logic signed [31:0] back_x;
    logic signed [31:0] back_y;
    logic signed [31:0] back_z;
    logic               forward_degenerate;
    logic               side_degenerate;
  } out_t;

  // Classified job: full-precision forward difference, the up vector and a zero-forward flag.
  typedef struct packed {
    logic signed [32:0] fwd_x;
    logic signed [32:0] fwd_y;
    logic signed [32:0] fwd_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
    logic               fwd_zero;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAG,
    S_SHIFT,
    S_SQ,
    S_SQRT,
    S_DSET,
    S_DIV,
    S_DFIN,
    S_CROSS,
    S_DONE
  } state_e;

  typedef enum logic {
    PH_FWD,
    PH_SIDE
  } phase_e;

endpackage

`default_nettype wire

FILE: rtl/lab_front.sv
// ----------------------------------------------------------------------------
// lab_front: input stage
// Accepts a transaction, forms the forward difference and flags a zero one.
// ----------------------------------------------------------------------------
`default_nettype none

module lab_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire lab_pkg::in_t  in_data_i,
  input  wire logic          fifo_full_i,
  output logic               job_valid_o,
  output lab_pkg::job_t      job_o
);

  logic          hold_valid_q, hold_valid_d;
  lab_pkg::job_t hold_q, hold_d;
  logic          accept;
  logic          push;

  assign push       = hold_valid_q && !fifo_full_i;
  assign in_stall_o = hold_valid_q && fifo_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    hold_valid_d = accept || (hold_valid_q && !push);
    hold_d       = hold_q;
    if (accept) begin
      hold_d.fwd_x = {in_data_i.target_x[31], in_data_i.target_x}
                   - {in_data_i.eye_x[31], in_data_i.eye_x};
      hold_d.fwd_y = {in_data_i.target_y[31], in_data_i.target_y}
                   - {in_data_i.eye_y[31], in_data_i.eye_y};
      hold_d.fwd_z = {in_data_i.target_z[31], in_data_i.target_z}
                   - {in_data_i.eye_z[31], in_data_i.eye_z};
      hold_d.up_x  = in_data_i.upvec_x;
      hold_d.up_y  = in_data_i.upvec_y;
      hold_d.up_z  = in_data_i.upvec_z;
      hold_d.fwd_zero = (in_data_i.target_x == in_data_i.eye_x)
                     && (in_data_i.target_y == in_data_i.eye_y)
                     && (in_data_i.target_z == in_data_i.eye_z);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

  assign job_valid_o = hold_valid_q;
  assign job_o       = hold_q;

endmodule

`default_nettype wire

FILE: rtl/lab_fifo.sv
// ----------------------------------------------------------------------------
// lab_fifo: two-entry job queue
// Decouples the input stage from the compute engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lab_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire lab_pkg::job_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output lab_pkg::job_t      data_o
);

  lab_pkg::job_t mem_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    count_q;
  logic          do_push;
  logic          do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

FILE: rtl/lab_back.sv
// ----------------------------------------------------------------------------
// lab_back: basis compute engine
// Sequences normalize, cross products, square root and divide on shared units.
// ----------------------------------------------------------------------------
`default_nettype none

module lab_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire lab_pkg::job_t job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output lab_pkg::out_t      out_data_o
);

  lab_pkg::state_e    state_q, state_d;
  lab_pkg::phase_e    phase_q, phase_d;
  logic [4:0]         cnt_q, cnt_d;
  logic               fdeg_q, fdeg_d, sdeg_q, sdeg_d;
  logic               out_valid_q, out_valid_d;
  lab_pkg::out_t      out_q, out_d;

  logic signed [31:0] up_q [3], up_d [3];
  logic signed [31:0] fwdn_q [3], fwdn_d [3];
  logic signed [31:0] siden_q [3], siden_d [3];
  logic signed [31:0] tup_q [3], tup_d [3];
  logic signed [63:0] v_q [3], v_d [3];
  logic [62:0]        m_q [3], m_d [3];
  logic [62:0]        mx_q, mx_d;
  logic [61:0]        s_q, s_d, x_q, x_d, r_q, r_d, b_q, b_d;
  logic [31:0]        rem_q [3], rem_d [3];
  logic [30:0]        num_q [3], num_d [3];
  logic [30:0]        quo_q [3], quo_d [3];
  logic signed [63:0] acc_q, acc_d, prod_q;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [31:0] opa_w [3], opb_w [3];
  logic [62:0]        mag_w [3];
  logic [62:0]        mxw;
  logic [62:0]        rb_w;
  logic [60:0]        numw [3];
  logic [32:0]        t_w [3];
  logic [32:0]        tr_w [3];
  logic signed [31:0] qs_w [3];
  logic [1:0]         idx_w;
  logic [2:0]         pk_w;
  logic [1:0]         comp_w;
  logic signed [63:0] diff_w;
  logic [63:0]        dmag_w;
  logic [63:0]        rnd_w;
  logic [32:0]        rs_w;
  logic signed [31:0] tupc_w;

  assign mul_p = mul_a * mul_b;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_w[i] = v_q[i][63] ? 63'(-v_q[i]) : v_q[i][62:0];
      numw[i]  = {1'b0, m_q[i][29:0], 30'b0} + 61'(r_q[30:1]);
      t_w[i]   = {rem_q[i], num_q[i][30]};
      tr_w[i]  = t_w[i] - {2'b0, r_q[30:0]};
      qs_w[i]  = v_q[i][63] ? 32'(32'd0 - {1'b0, quo_q[i]}) : {1'b0, quo_q[i]};
      opa_w[i] = (phase_q == lab_pkg::PH_FWD) ? fwdn_q[i] : siden_q[i];
      opb_w[i] = (phase_q == lab_pkg::PH_FWD) ? up_q[i] : fwdn_q[i];
    end
    mxw = mag_w[0];
    if (mag_w[1] > mxw) mxw = mag_w[1];
    if (mag_w[2] > mxw) mxw = mag_w[2];
    rb_w   = {1'b0, r_q} + {1'b0, b_q};
    idx_w  = (cnt_q[1:0] == 2'd3) ? 2'd0 : cnt_q[1:0];
    pk_w   = cnt_q[2:0] - 3'd1;
    comp_w = pk_w[2:1];
    diff_w = acc_q - prod_q;
    dmag_w = diff_w[63] ? 64'(-diff_w) : 64'(diff_w);
    rnd_w  = dmag_w + 64'h2000_0000;
    rs_w   = rnd_w[62:30];
    if (diff_w[63]) begin
      if (rs_w > 33'h0_8000_0000) rs_w = 33'h0_8000_0000;
      tupc_w = 32'(32'd0 - rs_w[31:0]);
    end else begin
      if (rs_w > 33'h0_7FFF_FFFF) rs_w = 33'h0_7FFF_FFFF;
      tupc_w = rs_w[31:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    fdeg_d      = fdeg_q;
    sdeg_d      = sdeg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    up_d        = up_q;
    fwdn_d      = fwdn_q;
    siden_d     = siden_q;
    tup_d       = tup_q;
    v_d         = v_q;
    m_d         = m_q;
    mx_d        = mx_q;
    s_d         = s_q;
    x_d         = x_q;
    r_d         = r_q;
    b_d         = b_q;
    rem_d       = rem_q;
    num_d       = num_q;
    quo_d       = quo_q;
    acc_d       = acc_q;
    job_pop_o   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;

    // drop the result once the receiver takes it
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      lab_pkg::S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          up_d[0] = job_i.up_x;
          up_d[1] = job_i.up_y;
          up_d[2] = job_i.up_z;
          v_d[0]  = {{31{job_i.fwd_x[32]}}, job_i.fwd_x};
          v_d[1]  = {{31{job_i.fwd_y[32]}}, job_i.fwd_y};
          v_d[2]  = {{31{job_i.fwd_z[32]}}, job_i.fwd_z};
          phase_d = lab_pkg::PH_FWD;
          cnt_d   = '0;
          if (job_i.fwd_zero) begin
            fdeg_d  = 1'b1;
            fwdn_d  = '{default: '0};
            state_d = lab_pkg::S_CROSS;
          end else begin
            fdeg_d  = 1'b0;
            state_d = lab_pkg::S_MAG;
          end
        end
      end
      lab_pkg::S_MAG: begin
        m_d  = mag_w;
        mx_d = mxw;
        if (mxw == '0) begin
          // zero vector stays zero
          if (phase_q == lab_pkg::PH_FWD) begin
            fwdn_d = '{default: '0};
            fdeg_d = 1'b1;
          end else begin
            siden_d = '{default: '0};
            sdeg_d  = 1'b1;
          end
          cnt_d   = '0;
          state_d = lab_pkg::S_CROSS;
        end else begin
          state_d = lab_pkg::S_SHIFT;
        end
      end
      lab_pkg::S_SHIFT: begin
        if (mx_q[62:38] != '0) begin
          mx_d = mx_q >> 8;
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] >> 8;
        end else if (mx_q[62:30] != '0) begin
          mx_d = mx_q >> 1;
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] >> 1;
        end else if (mx_q[29:21] == '0) begin
          mx_d = mx_q << 8;
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] << 8;
        end else if (!mx_q[29]) begin
          mx_d = mx_q << 1;
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] << 1;
        end else begin
          s_d     = '0;
          cnt_d   = '0;
          state_d = lab_pkg::S_SQ;
        end
      end
      lab_pkg::S_SQ: begin
        mul_a = {2'b0, m_q[idx_w][29:0]};
        mul_b = {2'b0, m_q[idx_w][29:0]};
        if (cnt_q != '0) s_d = s_q + prod_q[61:0];
        if (cnt_q == 5'd3) begin
          x_d     = s_q + prod_q[61:0];
          r_d     = '0;
          b_d     = 62'h1 << 60;
          cnt_d   = 5'd30;
          state_d = lab_pkg::S_SQRT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      lab_pkg::S_SQRT: begin
        if ({1'b0, x_q} >= rb_w) begin
          x_d = x_q - rb_w[61:0];
          r_d = (r_q >> 1) + b_q;
        end else begin
          r_d = r_q >> 1;
        end
        b_d = b_q >> 2;
        if (cnt_q == '0) state_d = lab_pkg::S_DSET;
        else cnt_d = cnt_q - 5'd1;
      end
      lab_pkg::S_DSET: begin
        for (int i = 0; i < 3; i++) begin
          rem_d[i] = {2'b0, numw[i][60:31]};
          num_d[i] = numw[i][30:0];
          quo_d[i] = '0;
        end
        cnt_d   = 5'd30;
        state_d = lab_pkg::S_DIV;
      end
      lab_pkg::S_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (t_w[i] >= {2'b0, r_q[30:0]}) begin
            rem_d[i] = tr_w[i][31:0];
            quo_d[i] = {quo_q[i][29:0], 1'b1};
          end else begin
            rem_d[i] = t_w[i][31:0];
            quo_d[i] = {quo_q[i][29:0], 1'b0};
          end
          num_d[i] = num_q[i] << 1;
        end
        if (cnt_q == '0) state_d = lab_pkg::S_DFIN;
        else cnt_d = cnt_q - 5'd1;
      end
      lab_pkg::S_DFIN: begin
        if (phase_q == lab_pkg::PH_FWD) begin
          fwdn_d = qs_w;
        end else begin
          siden_d = qs_w;
          sdeg_d  = 1'b0;
        end
        cnt_d   = '0;
        state_d = lab_pkg::S_CROSS;
      end
      lab_pkg::S_CROSS: begin
        case (cnt_q[2:0])
          3'd0: begin mul_a = opa_w[1]; mul_b = opb_w[2]; end
          3'd1: begin mul_a = opa_w[2]; mul_b = opb_w[1]; end
          3'd2: begin mul_a = opa_w[2]; mul_b = opb_w[0]; end
          3'd3: begin mul_a = opa_w[0]; mul_b = opb_w[2]; end
          3'd4: begin mul_a = opa_w[0]; mul_b = opb_w[1]; end
          3'd5: begin mul_a = opa_w[1]; mul_b = opb_w[0]; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        if (cnt_q != '0) begin
          if (!pk_w[0]) begin
            acc_d = prod_q;
          end else if (phase_q == lab_pkg::PH_FWD) begin
            v_d[comp_w] = diff_w;
          end else begin
            tup_d[comp_w] = tupc_w;
          end
        end
        if (cnt_q == 5'd6) begin
          if (phase_q == lab_pkg::PH_FWD) begin
            phase_d = lab_pkg::PH_SIDE;
            state_d = lab_pkg::S_MAG;
          end else begin
            state_d = lab_pkg::S_DONE;
          end
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      lab_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.side_x             = siden_q[0];
          out_d.side_y             = siden_q[1];
          out_d.side_z             = siden_q[2];
          out_d.true_up_x          = tup_q[0];
          out_d.true_up_y          = tup_q[1];
          out_d.true_up_z          = tup_q[2];
          out_d.back_x             = 32'(32'sd0 - fwdn_q[0]);
          out_d.back_y             = 32'(32'sd0 - fwdn_q[1]);
          out_d.back_z             = 32'(32'sd0 - fwdn_q[2]);
          out_d.forward_degenerate = fdeg_q;
          out_d.side_degenerate    = sdeg_q;
          out_valid_d              = 1'b1;
          state_d                  = lab_pkg::S_IDLE;
        end
      end
      default: state_d = lab_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lab_pkg::S_IDLE;
      phase_q     <= lab_pkg::PH_FWD;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fdeg_q  <= fdeg_d;
    sdeg_q  <= sdeg_d;
    out_q   <= out_d;
    up_q    <= up_d;
    fwdn_q  <= fwdn_d;
    siden_q <= siden_d;
    tup_q   <= tup_d;
    v_q     <= v_d;
    m_q     <= m_d;
    mx_q    <= mx_d;
    s_q     <= s_d;
    x_q     <= x_d;
    r_q     <= r_d;
    b_q     <= b_d;
    rem_q   <= rem_d;
    num_q   <= num_d;
    quo_q   <= quo_d;
    acc_q   <= acc_d;
    prod_q  <= mul_p;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/look_at_basis.sv
// ----------------------------------------------------------------------------
// look_at_basis: rotation rows of a look-at view matrix
// Usage:
//   Input channel: in_valid_i / in_stall_o with in_data_i carrying eye,
//   target and up vector in signed Q16.16. A transaction is taken on a rising
//   edge with valid high and stall low.
//   Output channel: out_valid_o / out_stall_i with out_data_o carrying side,
//   true up and back rows in signed Q1.30 plus two degenerate flags.
//   Every input transaction yields exactly one output transaction, in order.
//   The range-aligning shifts make the time to out_valid_o vary with each
//   normalization. A zero side skips the side normalization, and an eye
//   equal to the target skips both normalizations.
//   The engine handles one transaction at a time; its time per transaction
//   is set mostly by the bit-serial square root (31 steps) and the three
//   parallel bit-serial dividers (31 steps), run for forward and for side.
//   The input stage and a two-entry queue take up to three transactions
//   ahead of the engine, so the producer is held only once all three wait.
//   When the receiver stalls, the finished result holds in the output
//   register and the engine holds in its final state until it is taken.
//   Reset clears all valid state; nothing is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module look_at_basis (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire lab_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output lab_pkg::out_t      out_data_o
);

  // front to queue
  logic          front_valid;
  lab_pkg::job_t front_job;
  logic          fifo_full;

  // queue to engine
  logic          job_valid;
  lab_pkg::job_t job;
  logic          job_pop;

  // Accept transactions, form target minus eye at 33 bits, flag zero forward.
  lab_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .fifo_full_i (fifo_full),
    .job_valid_o (front_valid),
    .job_o       (front_job)
  );

  // Hold classified jobs so the front keeps accepting while the engine works.
  lab_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_job),
    .full_o  (fifo_full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .data_o  (job)
  );

  // Normalize forward, cross with up, normalize side, cross side with forward.
  lab_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
